[hw/rtl/gmms_pkg.sv]
package gmms_pkg;

  // frame store size and the address bits it needs
  localparam int MAX_PIXELS = 65536;
  localparam int PIX_AW     = $clog2(MAX_PIXELS);

  localparam int INDEX_W  = 16;
  localparam int SAMPLE_W = 24;
  localparam int GRAY_W   = 8;
  localparam int VALUE_W  = 32;

  // q16.16 one
  localparam int ONE_Q16 = 65536;

  // configuration register indexes
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_REMAP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd3;

  localparam logic [CFG_W-1:0] GAIN_RESET = 24'h010000;

endpackage

[hw/rtl/gmms_in_if.sv]
interface gmms_in_if
  import gmms_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [INDEX_W-1:0]         pixel_index;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       frame_start;

  modport source (output valid, mode, pixel_index, sample, frame_start, input ready);
  modport sink (input valid, mode, pixel_index, sample, frame_start, output ready);
endinterface

[hw/rtl/gmms_out_if.sv]
interface gmms_out_if
  import gmms_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] gray;

  modport source (output valid, gray, input ready);
  modport sink (input valid, gray, output ready);
endinterface

[hw/rtl/grayscale_min_max_stretch_core.sv]
// channel   dir  payload                                  handshake
// in        in   mode, pixel_index, sample, frame_start   valid / ready
// out       out  gray                                     valid / ready
// cfg       in   cfg_index, cfg_data                      cfg_write, no wait
//
// a load steps through accept, six radix-16 multiply digits of the serial multiplier, saturate, store.
// a readout leaves out the quotient bits when no stretch division is needed:
// accept, memory read, prepare, check, eight restoring radix-2 quotient bits, hand-off.
// the hand-off waits while the output register holds a result the sink has not taken.
// rst is synchronous; the frame store is not cleared, min and max are set to their start extremes.
// a new beat is taken as soon as the core is idle, even while the output
// register still holds a result that the sink has not taken.
module grayscale_min_max_stretch_core
  import gmms_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  gmms_in_if.sink              in,
  gmms_out_if.source           out,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LD_MUL   = 4'd1;
  localparam logic [3:0] S_LD_SAT   = 4'd2;
  localparam logic [3:0] S_LD_STORE = 4'd3;
  localparam logic [3:0] S_RD_MEM   = 4'd4;
  localparam logic [3:0] S_RD_PREP  = 4'd5;
  localparam logic [3:0] S_RD_CHK   = 4'd6;
  localparam logic [3:0] S_RD_DIV   = 4'd7;
  localparam logic [3:0] S_FIN      = 4'd8;

  localparam int MUL_DIGITS = SAMPLE_W / 4;
  localparam int HI_W       = SAMPLE_W + 6;

  logic [3:0] state;

  // configuration
  logic                    remap_enable;
  logic                    invert_enable;
  logic                    normalize_enable;
  logic signed [CFG_W-1:0] gain;

  // frame statistics
  logic signed [VALUE_W-1:0] min_value;
  logic signed [VALUE_W-1:0] max_value;

  // per-item registers
  logic [PIX_AW-1:0] op_addr;
  logic              op_frame_start;
  logic              op_out_of_range;

  // serial multiplier
  logic signed [SAMPLE_W-1:0] mul_v;
  logic [CFG_W-1:0]           mul_g;
  logic signed [HI_W-1:0]     mul_hi;
  logic [SAMPLE_W-1:0]        mul_lo;
  logic [2:0]                 mul_cnt;
  logic signed [VALUE_W-1:0]  store_val;

  // readout path
  logic [VALUE_W-1:0]        rd_data;
  logic signed [VALUE_W:0]   diff;
  logic [VALUE_W-1:0]        range_val;
  logic                      norm;
  logic [GRAY_W-1:0]         gray_clamp;
  logic [VALUE_W-1:0]        rem;
  logic [2:0]                div_cnt;
  logic [GRAY_W-1:0]         result;

  logic                      out_valid;
  logic [GRAY_W-1:0]         out_gray;

  logic [VALUE_W-1:0] frame_mem [MAX_PIXELS];

  logic                       accept;
  logic                       in_range;
  logic signed [SAMPLE_W:0]   remap_sum;
  logic signed [SAMPLE_W-1:0] v_in;
  logic signed [4:0]          digit;
  logic signed [HI_W-2:0]     part;
  logic signed [HI_W-1:0]     mul_sum;
  logic signed [VALUE_W-1:0]  scaled;
  logic signed [VALUE_W:0]    inv;
  logic signed [VALUE_W-1:0]  sat_val;
  logic signed [VALUE_W-1:0]  stored;
  logic [VALUE_W:0]           rem2;
  logic                       rem_ge;
  logic                       fin_load;

  assign accept   = in.valid && in.ready;
  assign in.ready = (state == S_IDLE);
  assign in_range = 32'(in.pixel_index) < 32'(MAX_PIXELS);

  // (v + 1) / 2, floor
  assign remap_sum = (SAMPLE_W+1)'(in.sample) + (SAMPLE_W+1)'(ONE_Q16);
  assign v_in      = remap_enable ? remap_sum[SAMPLE_W:1] : in.sample;

  // top gain digit carries the sign
  assign digit   = (mul_cnt == 3'(MUL_DIGITS - 1)) ? {mul_g[3], mul_g[3:0]}
                                                   : {1'b0, mul_g[3:0]};
  assign part    = (HI_W-1)'(mul_v) * (HI_W-1)'(digit);
  assign mul_sum = mul_hi + HI_W'(part);

  assign scaled  = {mul_hi[SAMPLE_W-1:0], mul_lo[SAMPLE_W-1:SAMPLE_W-8]};
  assign inv     = (VALUE_W+1)'(ONE_Q16) - (VALUE_W+1)'(scaled);

  always_comb begin
    sat_val = scaled;
    if (invert_enable) begin
      if (inv[VALUE_W] != inv[VALUE_W-1]) begin
        sat_val = inv[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
      end else begin
        sat_val = inv[VALUE_W-1:0];
      end
    end
  end

  assign stored = op_out_of_range ? '0 : rd_data;
  assign rem2   = {rem, 1'b0};
  assign rem_ge = rem2 >= (VALUE_W+1)'(range_val);

  assign fin_load = (state == S_FIN) && (!out_valid || out.ready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      remap_enable     <= 1'b0;
      invert_enable    <= 1'b0;
      normalize_enable <= 1'b0;
      gain             <= GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_REMAP:     remap_enable     <= cfg_data[0];
        CFG_INVERT:    invert_enable    <= cfg_data[0];
        CFG_NORMALIZE: normalize_enable <= cfg_data[0];
        CFG_GAIN:      gain             <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (state == S_LD_STORE) begin
      frame_mem[op_addr] <= store_val;
    end
    rd_data <= frame_mem[op_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      min_value <= {1'b0, {(VALUE_W-1){1'b1}}};
      max_value <= {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in.mode) begin
              state <= S_RD_MEM;
            end else if (in_range) begin
              state <= S_LD_MUL;
            end
          end
        end
        S_LD_MUL: begin
          if (mul_cnt == 3'(MUL_DIGITS - 1)) begin
            state <= S_LD_SAT;
          end
        end
        S_LD_SAT: state <= S_LD_STORE;
        S_LD_STORE: begin
          if (op_frame_start) begin
            min_value <= store_val;
            max_value <= store_val;
          end else begin
            if (store_val < min_value) min_value <= store_val;
            if (store_val > max_value) max_value <= store_val;
          end
          state <= S_IDLE;
        end
        S_RD_MEM:  state <= S_RD_PREP;
        S_RD_PREP: state <= S_RD_CHK;
        S_RD_CHK: begin
          if (!norm || diff[VALUE_W] || diff == '0 || diff >= (VALUE_W+1)'(range_val)) begin
            state <= S_FIN;
          end else begin
            state <= S_RD_DIV;
          end
        end
        S_RD_DIV: begin
          if (div_cnt == 3'd7) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_addr         <= PIX_AW'(in.pixel_index);
        op_frame_start  <= in.frame_start;
        op_out_of_range <= !in_range;
        mul_v           <= v_in;
        mul_g           <= gain;
        mul_hi          <= '0;
        mul_cnt         <= '0;
      end
      S_LD_MUL: begin
        mul_lo  <= {mul_sum[3:0], mul_lo[SAMPLE_W-1:4]};
        mul_hi  <= mul_sum >>> 4;
        mul_g   <= {4'b0, mul_g[CFG_W-1:4]};
        mul_cnt <= mul_cnt + 3'd1;
      end
      S_LD_SAT: store_val <= sat_val;
      S_RD_PREP: begin
        diff      <= (VALUE_W+1)'(stored) - (VALUE_W+1)'(min_value);
        range_val <= VALUE_W'((VALUE_W+1)'(max_value) - (VALUE_W+1)'(min_value));
        norm      <= normalize_enable && (max_value > min_value);
        if (stored[VALUE_W-1]) begin
          gray_clamp <= '0;
        end else if (stored > 32'sd65535) begin
          gray_clamp <= '1;
        end else begin
          gray_clamp <= stored[15:8];
        end
      end
      S_RD_CHK: begin
        rem     <= diff[VALUE_W-1:0];
        div_cnt <= '0;
        if (!norm) begin
          result <= gray_clamp;
        end else if (diff[VALUE_W] || diff == '0) begin
          result <= '0;
        end else begin
          // diff at or above range saturates; otherwise the divider overwrites this
          result <= '1;
        end
      end
      S_RD_DIV: begin
        rem     <= rem_ge ? VALUE_W'(rem2 - (VALUE_W+1)'(range_val)) : rem2[VALUE_W-1:0];
        result  <= {result[GRAY_W-2:0], rem_ge};
        div_cnt <= div_cnt + 3'd1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_gray <= result;
    end
  end

  assign out.valid = out_valid;
  assign out.gray  = out_gray;

endmodule
